// File: hw/rtl/illt_pkg.sv
package illt_pkg;

    // Table geometry
    localparam int DEPTH    = 512;
    localparam int KEY_BITS = 32;
    localparam int AW       = $clog2(DEPTH);
    localparam int LINK_W   = $clog2(DEPTH + 1);
    localparam int CNT_W    = $clog2(DEPTH);
    localparam int NODE_W   = LINK_W + 1;

    // Port field widths
    localparam int CMD_BITS  = 2;
    localparam int IKEY_BITS = 32;
    localparam int SLOT_BITS = 9;
    localparam int STAT_BITS = 2;

    // Link value that marks the end of the chain
    localparam logic [LINK_W-1:0] END_LINK = LINK_W'(DEPTH);

    typedef logic [KEY_BITS-1:0] t_key;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2,
        STAT_BAD  = 2'd3
    } t_status;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_INS_CHK,
        OP_INS_VAL,
        OP_INS_WR,
        OP_INS_LINK,
        OP_WALK_GO,
        OP_WALK,
        OP_UNLINK,
        OP_UNVALID,
        OP_RES
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
        logic    found;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic full;
        logic slot_bad;
        logic slot_used;
        logic head_end;
        logic hit;
        logic next_end;
    } t_dp_stat;

endpackage

// File: hw/rtl/illt_ram.sv
module illt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one port, read the other with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/illt_ctrl.sv
module illt_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [illt_pkg::CMD_BITS-1:0]     i_command,
    input  illt_pkg::t_dp_stat                i_stat,
    output logic                              busy,
    output illt_pkg::t_ctl                    o_ctl
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_INS_VAL,
        S_INS_WR,
        S_INS_LINK,
        S_WALK_GO,
        S_WALK,
        S_UNLINK,
        S_UNVALID,
        S_RES
    } t_state;

    t_state            r_state, n_state;
    illt_pkg::t_ctl    r_ctl, n_ctl;
    logic              r_is_remove, n_is_remove;
    illt_pkg::t_status n_status;
    logic              n_found;

    // Next state and result code
    always_comb begin
        n_state     = r_state;
        n_is_remove = r_is_remove;
        n_status    = illt_pkg::STAT_OK;
        n_found     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_is_remove = (i_command == illt_pkg::CMD_REMOVE);
                    case (i_command)
                        illt_pkg::CMD_INSERT: n_state = S_INS_CHK;
                        illt_pkg::CMD_REMOVE,
                        illt_pkg::CMD_SEARCH: n_state = S_WALK_GO;
                        default:              n_state = S_RES;
                    endcase
                end
            end
            S_INS_CHK: begin
                if (i_stat.full) begin
                    n_state  = S_RES;
                    n_status = illt_pkg::STAT_FULL;
                end else if (i_stat.slot_bad) begin
                    n_state  = S_RES;
                    n_status = illt_pkg::STAT_BAD;
                end else begin
                    n_state = S_INS_VAL;
                end
            end
            S_INS_VAL: begin
                if (i_stat.slot_used) begin
                    n_state  = S_RES;
                    n_status = illt_pkg::STAT_BAD;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR:   n_state = S_INS_LINK;
            S_INS_LINK: n_state = S_RES;
            S_WALK_GO: begin
                if (i_stat.head_end) begin
                    n_state  = S_RES;
                    n_status = illt_pkg::STAT_MISS;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.hit) begin
                    if (r_is_remove) begin
                        n_state = S_UNLINK;
                    end else begin
                        n_state = S_RES;
                        n_found = 1'b1;
                    end
                end else if (i_stat.next_end) begin
                    n_state  = S_RES;
                    n_status = illt_pkg::STAT_MISS;
                end
            end
            S_UNLINK: n_state = S_UNVALID;
            S_UNVALID: begin
                n_state = S_RES;
                n_found = 1'b1;
            end
            S_RES:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Map the next state onto a datapath operation
    always_comb begin
        n_ctl.status = n_status;
        n_ctl.found  = n_found;
        unique case (n_state)
            S_CLEAR:    n_ctl.op = illt_pkg::OP_CLEAR;
            S_IDLE:     n_ctl.op = illt_pkg::OP_IDLE;
            S_INS_CHK:  n_ctl.op = illt_pkg::OP_INS_CHK;
            S_INS_VAL:  n_ctl.op = illt_pkg::OP_INS_VAL;
            S_INS_WR:   n_ctl.op = illt_pkg::OP_INS_WR;
            S_INS_LINK: n_ctl.op = illt_pkg::OP_INS_LINK;
            S_WALK_GO:  n_ctl.op = illt_pkg::OP_WALK_GO;
            S_WALK:     n_ctl.op = illt_pkg::OP_WALK;
            S_UNLINK:   n_ctl.op = illt_pkg::OP_UNLINK;
            S_UNVALID:  n_ctl.op = illt_pkg::OP_UNVALID;
            S_RES:      n_ctl.op = illt_pkg::OP_RES;
            default:    n_ctl.op = illt_pkg::OP_IDLE;
        endcase
    end

    // Hold state and the registered command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ctl       <= '{op: illt_pkg::OP_CLEAR, status: illt_pkg::STAT_OK, found: 1'b0};
            r_is_remove <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctl       <= n_ctl;
            r_is_remove <= n_is_remove;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_ctl = r_ctl;

endmodule

// File: hw/rtl/illt_dpath.sv
module illt_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [illt_pkg::IKEY_BITS-1:0] i_key,
    input  logic [illt_pkg::SLOT_BITS-1:0]     i_slot,
    input  illt_pkg::t_ctl                     i_ctl,
    output illt_pkg::t_dp_stat                 o_stat,
    output logic                               o_done,
    output logic [illt_pkg::STAT_BITS-1:0]     o_status,
    output logic [illt_pkg::SLOT_BITS-1:0]     o_found_slot,
    output logic                               o_is_full,
    output logic                               o_is_empty,
    output logic [illt_pkg::SLOT_BITS-1:0]     o_entry_count
);

    localparam int AW     = illt_pkg::AW;
    localparam int LINK_W = illt_pkg::LINK_W;
    localparam int CNT_W  = illt_pkg::CNT_W;
    localparam int NODE_W = illt_pkg::NODE_W;

    illt_pkg::t_key              r_key;
    logic [illt_pkg::SLOT_BITS-1:0] r_slot;
    logic [LINK_W-1:0]           r_cur;
    logic [AW-1:0]               r_prev;
    logic [LINK_W-1:0]           r_head;
    logic [AW-1:0]               r_tail;
    logic [LINK_W-1:0]           r_hit_next;
    logic [CNT_W-1:0]            r_count;
    logic [AW-1:0]               r_clr;

    logic                        r_o_valid;
    illt_pkg::t_status           r_o_status;
    logic [illt_pkg::SLOT_BITS-1:0] r_o_found;
    logic                        r_o_full;
    logic                        r_o_empty;
    logic [illt_pkg::SLOT_BITS-1:0] r_o_count;

    logic                        node_we;
    logic [AW-1:0]               node_waddr;
    logic [NODE_W-1:0]           node_wdata;
    logic [AW-1:0]               rd_addr;
    logic [NODE_W-1:0]           node_rd;
    logic                        key_we;
    illt_pkg::t_key              key_rd;
    logic [LINK_W-1:0]           rd_next;
    logic                        rd_valid;
    logic                        key_hit;

    assign rd_next  = node_rd[LINK_W-1:0];
    assign rd_valid = node_rd[NODE_W-1];
    assign key_hit  = (key_rd == r_key);

    // Status back to the controller
    assign o_stat.clr_last  = (r_clr == AW'(illt_pkg::DEPTH - 1));
    assign o_stat.full      = (r_count >= CNT_W'(illt_pkg::DEPTH - 1));
    assign o_stat.slot_bad  = (r_slot == '0) || (int'(r_slot) >= illt_pkg::DEPTH);
    assign o_stat.slot_used = rd_valid;
    assign o_stat.head_end  = (r_head >= illt_pkg::END_LINK);
    assign o_stat.hit       = key_hit;
    assign o_stat.next_end  = (rd_next >= illt_pkg::END_LINK);

    // Select the read address; a walk follows the link just read
    always_comb begin
        case (i_ctl.op)
            illt_pkg::OP_INS_CHK: rd_addr = AW'(r_slot);
            illt_pkg::OP_WALK_GO: rd_addr = AW'(r_head);
            illt_pkg::OP_WALK:    rd_addr = AW'(rd_next);
            default:              rd_addr = AW'(r_cur);
        endcase
    end

    // Select the node write: {linked, next}
    always_comb begin
        node_we    = 1'b0;
        node_waddr = AW'(r_cur);
        node_wdata = '0;
        key_we     = 1'b0;
        case (i_ctl.op)
            illt_pkg::OP_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = r_clr;
            end
            illt_pkg::OP_INS_WR: begin
                node_we    = 1'b1;
                node_waddr = AW'(r_slot);
                node_wdata = {1'b1, illt_pkg::END_LINK};
                key_we     = 1'b1;
            end
            illt_pkg::OP_INS_LINK: begin
                node_we    = (r_tail != '0);
                node_waddr = r_tail;
                node_wdata = {1'b1, LINK_W'(r_slot)};
            end
            illt_pkg::OP_UNLINK: begin
                node_we    = (r_prev != '0);
                node_waddr = r_prev;
                node_wdata = {1'b1, r_hit_next};
            end
            illt_pkg::OP_UNVALID: begin
                node_we    = 1'b1;
                node_waddr = AW'(r_cur);
                node_wdata = {1'b0, r_hit_next};
            end
            default: begin
                node_we = 1'b0;
            end
        endcase
    end

    illt_ram #(
        .WIDTH(NODE_W),
        .DEPTH(illt_pkg::DEPTH)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(rd_addr),
        .o_rdata(node_rd)
    );

    illt_ram #(
        .WIDTH(illt_pkg::KEY_BITS),
        .DEPTH(illt_pkg::DEPTH)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(AW'(r_slot)),
        .i_wdata(r_key),
        .i_raddr(rd_addr),
        .o_rdata(key_rd)
    );

    // List control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= illt_pkg::END_LINK;
            r_tail    <= '0;
            r_count   <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (i_ctl.op == illt_pkg::OP_RES);
            case (i_ctl.op)
                illt_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                end
                illt_pkg::OP_INS_WR: begin
                    r_count <= r_count + CNT_W'(1);
                end
                illt_pkg::OP_INS_LINK: begin
                    if (r_tail == '0) begin
                        r_head <= LINK_W'(r_slot);
                    end
                    r_tail <= AW'(r_slot);
                end
                illt_pkg::OP_UNLINK: begin
                    if (r_prev == '0) begin
                        r_head <= r_hit_next;
                    end
                    if (r_tail == AW'(r_cur)) begin
                        r_tail <= r_prev;
                    end
                    r_count <= r_count - CNT_W'(1);
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    // Operand, walk and result registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            illt_pkg::OP_IDLE: begin
                r_key  <= illt_pkg::t_key'(i_key);
                r_slot <= i_slot;
            end
            illt_pkg::OP_WALK_GO: begin
                r_cur  <= r_head;
                r_prev <= '0;
            end
            illt_pkg::OP_WALK: begin
                r_hit_next <= rd_next;
                if (!key_hit) begin
                    r_cur  <= rd_next;
                    r_prev <= AW'(r_cur);
                end
            end
            illt_pkg::OP_RES: begin
                r_o_status <= i_ctl.status;
                r_o_found  <= i_ctl.found ? illt_pkg::SLOT_BITS'(r_cur) : '0;
                r_o_full   <= (r_count == CNT_W'(illt_pkg::DEPTH - 1));
                r_o_empty  <= (r_count == '0);
                r_o_count  <= illt_pkg::SLOT_BITS'(r_count);
            end
            default: begin
                r_slot <= r_slot;
            end
        endcase
    end

    assign o_done        = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_slot  = r_o_found;
    assign o_is_full     = r_o_full;
    assign o_is_empty    = r_o_empty;
    assign o_entry_count = r_o_count;

endmodule

// File: hw/rtl/index_linked_list_table.sv
// Array-backed singly linked list of keys with slot 0 as the head sentinel.
// Pulse start with a command while busy is low: insert (key into a chosen
// free slot, linked after the tail), remove (first matching key) or search
// (first matching key in link order). Exactly one result per command comes
// back on o_done for a single cycle, and it cannot be held off, so sample it
// when it appears. Insert checks for a full list and the sentinel slot, then
// whether the slot is already linked, and only then writes and links the node.
// Search and remove walk the chain from the head at one node per cycle
// through the read port of the link and key memories; a remove that hits then
// unlinks the node and clears its valid bit. An unused command goes straight
// to the result. The result beat arrives in the first cycle with busy low, so
// the next command can be accepted at the same edge that takes the beat.
// After reset, busy stays high while the slot-valid bits in the link memory
// are cleared.
module index_linked_list_table (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [illt_pkg::CMD_BITS-1:0]         i_command,
    input  logic signed [illt_pkg::IKEY_BITS-1:0] i_key,
    input  logic [illt_pkg::SLOT_BITS-1:0]        i_slot,
    output logic                                  o_done,
    output logic [illt_pkg::STAT_BITS-1:0]        o_status,
    output logic [illt_pkg::SLOT_BITS-1:0]        o_found_slot,
    output logic                                  o_is_full,
    output logic                                  o_is_empty,
    output logic [illt_pkg::SLOT_BITS-1:0]        o_entry_count
);

    illt_pkg::t_ctl     ctl;
    illt_pkg::t_dp_stat stat;

    illt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_command),
        .i_stat   (stat),
        .busy     (busy),
        .o_ctl    (ctl)
    );

    illt_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_slot       (i_slot),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found_slot (o_found_slot),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty),
        .o_entry_count(o_entry_count)
    );

`ifndef SYNTHESIS
    // A result beat only arrives once the controller is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // An accepted command always occupies the controller
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // Failed commands report no slot
    a_fail_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == illt_pkg::STAT_FULL || o_status == illt_pkg::STAT_MISS
            || o_status == illt_pkg::STAT_BAD)) |-> (o_found_slot == '0))
        else $error("slot reported on a failed command");

    // A full status must agree with the full flag
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == illt_pkg::STAT_FULL) |-> o_is_full)
        else $error("full status without full flag");
`endif

endmodule

// File: tb/index_linked_list_table_tb.sv
module index_linked_list_table_tb;

    localparam int CLK_PERIOD = 12;
    localparam int RST_CYCLES = 9;
    localparam longint TIMEOUT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MIXED_ITEMS = 30;
    localparam int AT_FULL_ITEMS = 24;
    localparam int POOL_SIZE = 12;
    // command code the block leaves unused
    localparam logic [illt_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        illt_pkg::t_status                status;
        logic [illt_pkg::SLOT_BITS-1:0]   found;
        logic                             full;
        logic                             empty;
        logic [illt_pkg::SLOT_BITS-1:0]   count;
    } t_list_reply;

    // Shadow copy of the list: updated per accepted command, holds the
    // replies still owed by the block.
    class list_shadow;
        logic [illt_pkg::LINK_W-1:0] next_of [illt_pkg::DEPTH];
        illt_pkg::t_key              key_of [illt_pkg::DEPTH];
        bit                          used [illt_pkg::DEPTH];
        logic [illt_pkg::LINK_W-1:0] head;
        int unsigned                 tail;
        int unsigned                 count;
        t_list_reply                 pending_replies[$];
        int unsigned                 mismatches;

        function new();
            head = illt_pkg::END_LINK;
            tail = 0;
            count = 0;
            mismatches = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void set_link(int unsigned s, logic [illt_pkg::LINK_W-1:0] v);
            if (s == 0) begin
                head = v;
            end else begin
                next_of[s] = v;
            end
        endfunction

        // Walk in link order; return the first matching slot or DEPTH.
        function int unsigned find_key(illt_pkg::t_key k, output int unsigned prev);
            int unsigned cur;
            int unsigned steps;
            prev = 0;
            cur = head;
            steps = 0;
            while (cur < illt_pkg::DEPTH && steps < illt_pkg::DEPTH) begin
                if (key_of[cur] == k) return cur;
                prev = cur;
                cur = next_of[cur];
                steps++;
            end
            prev = 0;
            return illt_pkg::DEPTH;
        endfunction

        function void note_command(logic [illt_pkg::CMD_BITS-1:0] cmd,
                                   illt_pkg::t_key k,
                                   logic [illt_pkg::SLOT_BITS-1:0] s);
            t_list_reply r;
            int unsigned hit;
            int unsigned prev;
            r.status = illt_pkg::STAT_OK;
            r.found = '0;
            if (cmd == illt_pkg::CMD_INSERT) begin
                if (count >= illt_pkg::DEPTH - 1) begin
                    r.status = illt_pkg::STAT_FULL;
                end else if (s == 0 || s >= illt_pkg::DEPTH || used[s]) begin
                    r.status = illt_pkg::STAT_BAD;
                end else begin
                    key_of[s] = k;
                    next_of[s] = illt_pkg::END_LINK;
                    used[s] = 1'b1;
                    set_link(tail, illt_pkg::LINK_W'(s));
                    tail = s;
                    count++;
                end
            end else if (cmd == illt_pkg::CMD_REMOVE) begin
                hit = find_key(k, prev);
                if (hit >= illt_pkg::DEPTH) begin
                    r.status = illt_pkg::STAT_MISS;
                end else begin
                    // unlink; pull the tail back when the tail goes
                    set_link(prev, next_of[hit]);
                    if (tail == hit) tail = prev;
                    used[hit] = 1'b0;
                    if (count > 0) count--;
                    r.found = illt_pkg::SLOT_BITS'(hit);
                end
            end else if (cmd == illt_pkg::CMD_SEARCH) begin
                hit = find_key(k, prev);
                if (hit >= illt_pkg::DEPTH) begin
                    r.status = illt_pkg::STAT_MISS;
                end else begin
                    r.found = illt_pkg::SLOT_BITS'(hit);
                end
            end
            r.full = (count == illt_pkg::DEPTH - 1);
            r.empty = (count == 0);
            r.count = illt_pkg::SLOT_BITS'(count);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [illt_pkg::STAT_BITS-1:0] status,
                                  logic [illt_pkg::SLOT_BITS-1:0] found, logic full,
                                  logic empty, logic [illt_pkg::SLOT_BITS-1:0] cnt);
            t_list_reply e;
            if (pending_replies.size() == 0) begin
                $error("result beat with nothing pending: status %0d slot %0d",
                       status, found);
                mismatches++;
                return;
            end
            e = pending_replies.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                mismatches++;
            end
            if (found !== e.found) begin
                $error("found_slot: expected %0d, actual %0d", e.found, found);
                mismatches++;
            end
            if (full !== e.full) begin
                $error("is_full: expected %0d, actual %0d", e.full, full);
                mismatches++;
            end
            if (empty !== e.empty) begin
                $error("is_empty: expected %0d, actual %0d", e.empty, empty);
                mismatches++;
            end
            if (cnt !== e.count) begin
                $error("entry_count: expected %0d, actual %0d", e.count, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic [illt_pkg::CMD_BITS-1:0]         i_command;
    logic signed [illt_pkg::IKEY_BITS-1:0] i_key;
    logic [illt_pkg::SLOT_BITS-1:0]        i_slot;
    logic                                  o_done;
    logic [illt_pkg::STAT_BITS-1:0]        o_status;
    logic [illt_pkg::SLOT_BITS-1:0]        o_found_slot;
    logic                                  o_is_full;
    logic                                  o_is_empty;
    logic [illt_pkg::SLOT_BITS-1:0]        o_entry_count;

    list_shadow     shadow;
    int unsigned    idle_pct;
    illt_pkg::t_key key_pool [POOL_SIZE];

    index_linked_list_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_slot       (i_slot),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_found_slot (o_found_slot),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Check every result beat against the oldest pending reply
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            shadow.check_reply(o_status, o_found_slot, o_is_full, o_is_empty,
                               o_entry_count);
        end
    end

    // Hold start with the command until a beat is taken; note it at once.
    // Called at a rising edge, returns at the edge that took the beat.
    task automatic issue(input logic [illt_pkg::CMD_BITS-1:0] cmd,
                         input illt_pkg::t_key k,
                         input logic [illt_pkg::SLOT_BITS-1:0] s);
        int unsigned gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(12, 40)
                                           : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_key     <= k;
        i_slot    <= s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.note_command(cmd, k, s);
    endtask

    function automatic logic [illt_pkg::SLOT_BITS-1:0] pick_free();
        int unsigned s;
        int unsigned c;
        s = $urandom_range(1, illt_pkg::DEPTH - 1);
        if (shadow.count >= illt_pkg::DEPTH - 1) return illt_pkg::SLOT_BITS'(s);
        for (int i = 0; i < 8; i++) begin
            if (!shadow.used[s]) return illt_pkg::SLOT_BITS'(s);
            s = $urandom_range(1, illt_pkg::DEPTH - 1);
        end
        for (int i = 0; i < illt_pkg::DEPTH; i++) begin
            c = (s + i) % illt_pkg::DEPTH;
            if (c != 0 && !shadow.used[c]) return illt_pkg::SLOT_BITS'(c);
        end
        return illt_pkg::SLOT_BITS'(s);
    endfunction

    function automatic logic [illt_pkg::SLOT_BITS-1:0] pick_linked();
        int unsigned s;
        int unsigned c;
        s = $urandom_range(1, illt_pkg::DEPTH - 1);
        for (int i = 0; i < 16; i++) begin
            if (shadow.used[s]) return illt_pkg::SLOT_BITS'(s);
            s = $urandom_range(1, illt_pkg::DEPTH - 1);
        end
        for (int i = 0; i < illt_pkg::DEPTH; i++) begin
            c = (s + i) % illt_pkg::DEPTH;
            if (shadow.used[c]) return illt_pkg::SLOT_BITS'(c);
        end
        return '0;
    endfunction

    // Draw one command; fill mode leans hard on good inserts
    task automatic random_command(input bit fill);
        int unsigned r;
        int unsigned r2;
        int unsigned zero_pct;
        int unsigned used_pct;
        logic [illt_pkg::CMD_BITS-1:0] cmd;
        illt_pkg::t_key k;
        logic [illt_pkg::SLOT_BITS-1:0] s;
        r = $urandom_range(99);
        r2 = $urandom_range(99);
        zero_pct = fill ? 2 : 6;
        used_pct = fill ? 4 : 14;
        if (fill) begin
            cmd = (r < 94) ? illt_pkg::CMD_INSERT : (r < 96) ? illt_pkg::CMD_REMOVE :
                  (r < 99) ? illt_pkg::CMD_SEARCH : CMD_UNUSED;
        end else begin
            cmd = (r < 40) ? illt_pkg::CMD_INSERT : (r < 65) ? illt_pkg::CMD_REMOVE :
                  (r < 93) ? illt_pkg::CMD_SEARCH : CMD_UNUSED;
        end
        s = illt_pkg::SLOT_BITS'($urandom_range(illt_pkg::DEPTH - 1));
        k = ($urandom_range(99) < 60) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                      : illt_pkg::t_key'($urandom);
        if (cmd == illt_pkg::CMD_INSERT) begin
            if (r2 < zero_pct) begin
                s = '0;
            end else if (r2 < used_pct && shadow.count > 0) begin
                s = pick_linked();
            end else begin
                s = pick_free();
            end
        end else if (cmd == illt_pkg::CMD_REMOVE || cmd == illt_pkg::CMD_SEARCH) begin
            if (r2 < 50 && shadow.count > 0) begin
                k = shadow.key_of[pick_linked()];
            end else if (r2 < 80) begin
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                k = illt_pkg::t_key'($urandom);
            end
        end
        issue(cmd, k, s);
    endtask

    initial begin
        shadow = new();
        idle_pct = 0;
        start     <= 1'b0;
        i_command <= illt_pkg::CMD_INSERT;
        i_key     <= '0;
        i_slot    <= '0;
        i_rst_n   <= 1'b0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        key_pool[4] = 32'd500;
        for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = illt_pkg::t_key'($urandom);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: misses, unused command, sentinel slot
        issue(illt_pkg::CMD_SEARCH, 32'h0000_0000, 9'd0);
        issue(illt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 9'd0);
        issue(CMD_UNUSED, illt_pkg::t_key'($urandom), 9'd5);
        issue(illt_pkg::CMD_INSERT, 32'd7, 9'd0);
        // Build a short chain with extreme keys and slots
        issue(illt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 9'd511);
        issue(illt_pkg::CMD_INSERT, 32'h8000_0000, 9'd1);
        issue(illt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 9'd256);
        issue(illt_pkg::CMD_INSERT, 32'd1, 9'd511);
        issue(illt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 9'd2);
        // Duplicate key: first in link order wins
        issue(illt_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 9'd0);
        issue(illt_pkg::CMD_SEARCH, 32'h8000_0000, 9'd0);
        issue(illt_pkg::CMD_SEARCH, 32'd500, 9'd0);
        // Remove head, middle, then tail; insert must link after new tail
        issue(illt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 9'd0);
        issue(illt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 9'd0);
        issue(illt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 9'd0);
        issue(illt_pkg::CMD_INSERT, 32'd500, 9'd170);
        issue(illt_pkg::CMD_SEARCH, 32'd500, 9'd0);
        issue(CMD_UNUSED, 32'h0000_0000, 9'd0);
        // Drain to empty through a lone head-and-tail entry
        issue(illt_pkg::CMD_REMOVE, 32'h8000_0000, 9'd0);
        issue(illt_pkg::CMD_REMOVE, 32'd500, 9'd0);
        issue(illt_pkg::CMD_INSERT, 32'h0000_0000, 9'd85);
        issue(illt_pkg::CMD_SEARCH, 32'h0000_0000, 9'd0);
        issue(illt_pkg::CMD_REMOVE, 32'h0000_0000, 9'd0);

        // Mixed traffic, back-to-back then with a busy sender
        idle_pct = 0;
        for (int i = 0; i < MIXED_ITEMS; i++) random_command(1'b0);
        idle_pct = 62;
        for (int i = 0; i < MIXED_ITEMS; i++) random_command(1'b0);
        // Fill the table, then keep pushing against the full list
        idle_pct = 12;
        while (shadow.count < illt_pkg::DEPTH - 1) random_command(1'b1);
        idle_pct = 62;
        for (int i = 0; i < AT_FULL_ITEMS; i++) random_command(1'b1);
        start <= 1'b0;

        // Wait out the last replies, then idle for DRAIN_CYCLES
        while (shadow.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0) begin
            $display("index_linked_list_table test passed");
        end else begin
            $display("index_linked_list_table test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("index_linked_list_table test failed");
        $finish;
    end

endmodule
